FILE: rtl/spq_pkg.sv
// Shared types and codes for the stable priority queue.
`timescale 1ns / 1ps
package spq_pkg;

    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [1:0] REQ_PEEK    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [31:0] VALUE_EMPTY = -32'sd1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] item_value;
        logic [7:0]         item_priority;
    } req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
        logic [4:0]         entry_count;
    } rsp_t;

    // One stored entry of the sorted chain.
    typedef struct packed {
        logic signed [31:0] value;
        logic [7:0]         prio;
    } entry_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
// One cell of the sorted chain: holds an entry, shifts toward either neighbor.
`timescale 1ns / 1ps
module spq_cell
(
    input  logic                clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::entry_t     new_entry,
    input  logic                occupied,
    input  logic                prev_stay,
    input  spq_pkg::entry_t     prev_entry,
    input  spq_pkg::entry_t     next_entry,
    output logic                stay,
    output spq_pkg::entry_t     entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // Keep an occupied entry when it outranks or ties the incoming one.
    assign stay  = occupied && (entry_reg.prio >= new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins && !stay)
        begin
            // The first cell that yields takes the new entry, the rest shift back.
            entry_next = prev_stay ? new_entry : prev_entry;
        end
        else if (ctrl.del)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: rtl/stable_priority_queue.sv
// Top level of the stable priority queue: cell chain, entry count, result register.
//
// Usage: drive req with start high while busy is low; that beat is accepted.
// req.req_type selects enqueue, dequeue or peek. Enqueue places the value
// behind every stored entry of equal or higher priority, so ties leave first
// in, first out. Dequeue returns and removes the front value, peek returns it
// and keeps it. An empty queue answers -1 with an empty status; a full queue
// refuses an enqueue with a full status.
// The result beat appears on rsp with done high in the cycle after
// the accepting edge, for exactly one cycle. The queue takes one request per
// cycle; every cell compares against the incoming priority and shifts in
// parallel, so busy stays low.
// Reset: rst_n clears the entry count and the result strobe; stored entries
// are not cleared and are never read before they are written.
// The receiver cannot stall: each result is taken on the cycle it is shown.
`timescale 1ns / 1ps
module stable_priority_queue
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::req_t req,
    output logic          done,
    output spq_pkg::rsp_t rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                done_reg;
    spq_pkg::rsp_t       rsp_reg;
    spq_pkg::rsp_t       rsp_next;
    spq_pkg::cell_ctrl_t ctrl;
    spq_pkg::entry_t     new_entry;
    spq_pkg::entry_t     entry_w [QUEUE_DEPTH];
    logic                stay_w  [QUEUE_DEPTH];
    logic                accept;
    logic                empty;
    logic                full;
    logic [31:0]         count_ext;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CW'(QUEUE_DEPTH));

    assign new_entry.value = req.item_value;
    assign new_entry.prio  = req.item_priority;

    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        rsp_next   = '0;
        rsp_next.status = spq_pkg::ST_OK;
        if (accept)
        begin
            case (req.req_type)
                spq_pkg::REQ_ENQUEUE:
                begin
                    if (full)
                    begin
                        rsp_next.status = spq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                spq_pkg::REQ_DEQUEUE,
                spq_pkg::REQ_PEEK:
                begin
                    if (empty)
                    begin
                        rsp_next.result_value = spq_pkg::VALUE_EMPTY;
                        rsp_next.status       = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rsp_next.result_value = entry_w[0].value;
                        if (req.req_type == spq_pkg::REQ_DEQUEUE)
                        begin
                            ctrl.del   = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    // Unused code: leave the queue as it is.
                    count_next = count_reg;
                end
            endcase
        end
        count_ext            = 32'(count_next);
        rsp_next.entry_count = count_ext[4:0];
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        spq_pkg::entry_t prev_entry;
        spq_pkg::entry_t next_entry;
        logic            prev_stay;

        if (i == 0)
        begin : g_head
            assign prev_entry = new_entry;
            assign prev_stay  = 1'b1;
        end
        else
        begin : g_body
            assign prev_entry = entry_w[i-1];
            assign prev_stay  = stay_w[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign next_entry = entry_w[i];
        end
        else
        begin : g_link
            assign next_entry = entry_w[i+1];
        end

        spq_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_entry  (new_entry),
            .occupied   (count_reg > CW'(i)),
            .prev_stay  (prev_stay),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .stay       (stay_w[i]),
            .entry      (entry_w[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

FILE: rtl/spq_checker.sv
// Port-level checks for the stable priority queue, bound to the top level.
`timescale 1ns / 1ps
module spq_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input spq_pkg::req_t req,
    input logic          done,
    input spq_pkg::rsp_t rsp
);

    // Every accepted beat answers in the next cycle.
    a_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted request got no result");

    // No result without a request.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without request");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == spq_pkg::ST_EMPTY) |->
            (rsp.result_value == spq_pkg::VALUE_EMPTY && rsp.entry_count == 5'd0))
        else $error("empty result malformed");

    // A refused beat was an enqueue and returns zero.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == spq_pkg::ST_FULL) |->
            (rsp.result_value == 32'sd0 && $past(req.req_type) == spq_pkg::REQ_ENQUEUE))
        else $error("full result malformed");

    // On a full refusal that follows another result, the count stays or grows by one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && rsp.status == spq_pkg::ST_FULL) |->
            (rsp.entry_count == $past(rsp.entry_count)
             || rsp.entry_count == $past(rsp.entry_count) + 5'd1))
        else $error("count jumped on full refusal");

endmodule

bind stable_priority_queue spq_checker u_spq_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);
